// File: hdl/pspm_pkg.sv
// shared types and constants of the plot sample to pixel mapper
package pspm_pkg;

    localparam logic [1:0] MODE_FIXED   = 2'd0;
    localparam logic [1:0] MODE_DYNAMIC = 2'd1;
    localparam logic [1:0] MODE_XY      = 2'd2;

    localparam logic OP_PLOT  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_X_MIN     = 3'd1;
    localparam logic [2:0] REG_X_MAX     = 3'd2;
    localparam logic [2:0] REG_Y_MIN     = 3'd3;
    localparam logic [2:0] REG_Y_MAX     = 3'd4;
    localparam logic [2:0] REG_WIDTH     = 3'd5;
    localparam logic [2:0] REG_HEIGHT    = 3'd6;
    localparam logic [2:0] REG_MIN_SLOTS = 3'd7;

    localparam int IDX_W  = 32;
    localparam int SLOT_W = 33;
    localparam int NUM_W  = 45;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x_min;
        logic signed [31:0] x_max;
        logic signed [31:0] y_min;
        logic signed [31:0] y_max;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [15:0]        min_slots;
    } cfg_t;

    typedef struct packed {
        logic               linear;
        logic               rescale;
        logic [IDX_W-1:0]   idx;
        logic [SLOT_W-1:0]  slots;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } job_t;

    typedef struct packed {
        logic [23:0] sample_index;
        logic        rescale;
        logic        dot_visible;
        logic [11:0] line_from_y;
        logic [11:0] line_from_x;
        logic        line_valid;
        logic [11:0] pixel_y;
        logic [11:0] pixel_x;
    } result_t;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_MUL, F_PUSH} front_state_t;

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_FIN, B_OUT} back_state_t;

endpackage

// File: hdl/pspm_front.sv
// front end: accepts samples, keeps the sample count and works out the x slot count
module pspm_front #(
    parameter int COUNT_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pspm_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_opcode,
    input  logic signed [31:0]  in_x,
    input  logic signed [31:0]  in_y,
    input  logic                q_full,
    output logic                q_push,
    output pspm_pkg::job_t      q_data
);

    localparam int NW     = COUNT_BITS + 1;
    localparam int SW     = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam int STEP_W = $clog2(NW + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    pspm_pkg::front_state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] idx_reg, idx_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [16:0]           rem_reg, rem_next;
    logic [15:0]           pm_reg, pm_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SW-1:0]         slots_reg, slots_next;
    logic [SW-1:0]         last_reg, last_next;
    logic                  linear_reg, linear_next;
    logic signed [31:0]    x_reg, x_next, y_reg, y_next;

    logic [NW-1:0]         n_in;
    logic [15:0]           pm_in;
    logic [16:0]           trial;
    logic                  ge;
    logic [NW+16:0]        prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pspm_pkg::F_IDLE;
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        pm_reg     <= pm_next;
        step_reg   <= step_next;
        slots_reg  <= slots_next;
        linear_reg <= linear_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        pm_next     = pm_reg;
        step_next   = step_reg;
        slots_next  = slots_reg;
        linear_next = linear_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        in_ready    = 1'b0;
        q_push      = 1'b0;

        n_in  = {1'b0, count_reg} + NW'(1);
        pm_in = (cfg.min_slots == 16'd0) ? 16'd1 : cfg.min_slots;
        trial = {rem_reg[15:0], n_reg[NW-1]};
        ge    = (trial >= {1'b0, pm_reg});
        prod  = pm_reg * ({1'b0, n_reg} + (NW+1)'(1));

        q_data.linear  = linear_reg;
        q_data.rescale = linear_reg && (slots_reg != last_reg);
        q_data.idx     = pspm_pkg::IDX_W'(idx_reg);
        q_data.slots   = pspm_pkg::SLOT_W'(slots_reg);
        q_data.x_value = x_reg;
        q_data.y_value = y_reg;

        unique case (state_reg)
            pspm_pkg::F_IDLE:
            begin
                in_ready = !q_full;
                if (in_valid && !q_full)
                begin
                    if (in_opcode == pspm_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        count_next = (count_reg == CMAX) ? count_reg : count_reg + 1'b1;
                        pm_next    = pm_in;
                        x_next     = in_x;
                        y_next     = in_y;
                        if (cfg.mode == pspm_pkg::MODE_FIXED)
                        begin
                            linear_next = 1'b1;
                            n_next      = n_in;
                            rem_next    = '0;
                            step_next   = STEP_W'(NW);
                            state_next  = pspm_pkg::F_DIV;
                        end
                        else if (cfg.mode == pspm_pkg::MODE_DYNAMIC)
                        begin
                            linear_next = 1'b1;
                            slots_next  = (n_in > NW'(pm_in)) ? SW'(n_in) : SW'(pm_in);
                            state_next  = pspm_pkg::F_PUSH;
                        end
                        else
                        begin
                            linear_next = 1'b0;
                            state_next  = pspm_pkg::F_PUSH;
                        end
                    end
                end
            end
            pspm_pkg::F_DIV:
            begin
                // restoring division of the slot number by the minimum slot count
                rem_next  = ge ? (trial - {1'b0, pm_reg}) : trial;
                n_next    = {n_reg[NW-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = pspm_pkg::F_MUL;
                end
            end
            pspm_pkg::F_MUL:
            begin
                slots_next = prod[SW-1:0];
                state_next = pspm_pkg::F_PUSH;
            end
            pspm_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    if (linear_reg)
                    begin
                        last_next = slots_reg;
                    end
                    state_next = pspm_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = pspm_pkg::F_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/pspm_queue.sv
// two entry job queue between front and back end
module pspm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pspm_pkg::job_t push_data,
    input  logic           pop,
    output pspm_pkg::job_t pop_data,
    output logic           full,
    output logic           empty
);

    pspm_pkg::job_t mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] fill_reg, fill_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_comb
    begin
        full      = (fill_reg == 2'd2);
        empty     = (fill_reg == 2'd0);
        pop_data  = mem_reg[rd_reg];
        wr_next   = push ? !wr_reg : wr_reg;
        rd_next   = pop ? !rd_reg : rd_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

endmodule

// File: hdl/pspm_back.sv
// back end: scales both axes through a shared multiplier and serial divider
module pspm_back #(
    parameter int DOT_RADIUS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pspm_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  pspm_pkg::job_t    q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output pspm_pkg::result_t out_data
);

    localparam int NW = pspm_pkg::NUM_W;
    localparam logic [13:0] DOT = 14'(DOT_RADIUS);

    pspm_pkg::back_state_t state_reg, state_next;
    pspm_pkg::job_t        job_reg, job_next;
    logic                  axis_reg, axis_next;
    logic signed [45:0]    prod_reg, prod_next;
    logic [NW-1:0]         num_reg, num_next;
    logic [32:0]           den_reg, den_next;
    logic [33:0]           rem_reg, rem_next;
    logic [5:0]            step_reg, step_next;
    logic [11:0]           px_reg, px_next;
    logic [11:0]           prev_x_reg, prev_x_next;
    logic [11:0]           prev_y_reg, prev_y_next;
    logic                  valid_reg, valid_next;
    pspm_pkg::result_t     res_reg, res_next;

    logic signed [31:0] v, lo, hi;
    logic [11:0]        m;
    logic signed [32:0] range, diff, op_a;
    logic signed [12:0] op_b;
    logic [33:0]        trial;
    logic               ge;
    logic [11:0]        clamped, py;
    logic               dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pspm_pkg::B_IDLE;
            valid_reg  <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        axis_reg <= axis_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        px_reg   <= px_next;
        res_reg  <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        axis_next   = axis_reg;
        prod_next   = prod_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        px_next     = px_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        res_next    = res_reg;
        valid_next  = valid_reg && !out_ready;
        q_pop       = 1'b0;

        v     = axis_reg ? job_reg.y_value : job_reg.x_value;
        lo    = axis_reg ? cfg.y_min : cfg.x_min;
        hi    = axis_reg ? cfg.y_max : cfg.x_max;
        m     = axis_reg ? cfg.height : cfg.width;
        range = 33'(hi) - 33'(lo);
        diff  = 33'(v) - 33'(lo);
        op_a  = (!axis_reg && job_reg.linear) ? $signed({1'b0, job_reg.idx}) : diff;
        op_b  = $signed({1'b0, m});
        trial = {rem_reg[32:0], num_reg[NW-1]};
        ge    = (trial >= {1'b0, den_reg});
        clamped = (num_reg > NW'(m)) ? m : num_reg[11:0];
        py    = cfg.height - clamped;
        dot   = ({2'b0, px_reg} > DOT) && (({2'b0, px_reg} + DOT) < {2'b0, cfg.width})
             && ({2'b0, py} > DOT) && (({2'b0, py} + DOT) < {2'b0, cfg.height});

        unique case (state_reg)
            pspm_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    axis_next  = 1'b0;
                    state_next = pspm_pkg::B_MUL;
                end
            end
            pspm_pkg::B_MUL:
            begin
                prod_next  = op_a * op_b;
                state_next = pspm_pkg::B_PREP;
            end
            pspm_pkg::B_PREP:
            begin
                rem_next  = '0;
                step_next = 6'(NW);
                if (!axis_reg && job_reg.linear)
                begin
                    num_next   = prod_reg[NW-1:0];
                    den_next   = job_reg.slots;
                    state_next = pspm_pkg::B_DIV;
                end
                else if (range == 33'sd0)
                begin
                    // empty window: integer part of the value itself
                    num_next   = v[31] ? '0 : NW'(v[31:16]);
                    state_next = pspm_pkg::B_FIN;
                end
                else if (prod_reg == 46'sd0 || (prod_reg[45] != range[32]))
                begin
                    num_next   = '0;
                    state_next = pspm_pkg::B_FIN;
                end
                else
                begin
                    num_next   = prod_reg[45] ? NW'(-prod_reg) : NW'(prod_reg);
                    den_next   = range[32] ? 33'(-range) : 33'(range);
                    state_next = pspm_pkg::B_DIV;
                end
            end
            pspm_pkg::B_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, den_reg}) : trial;
                num_next  = {num_reg[NW-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd1)
                begin
                    state_next = pspm_pkg::B_FIN;
                end
            end
            pspm_pkg::B_FIN:
            begin
                if (!axis_reg)
                begin
                    px_next    = clamped;
                    axis_next  = 1'b1;
                    state_next = pspm_pkg::B_MUL;
                end
                else
                begin
                    num_next   = NW'(py);
                    state_next = pspm_pkg::B_OUT;
                end
            end
            pspm_pkg::B_OUT:
            begin
                // num holds the flipped y pixel here
                if (!valid_reg || out_ready)
                begin
                    res_next.pixel_x      = px_reg;
                    res_next.pixel_y      = num_reg[11:0];
                    res_next.line_valid   = (job_reg.idx != '0);
                    res_next.line_from_x  = prev_x_reg;
                    res_next.line_from_y  = prev_y_reg;
                    res_next.dot_visible  =
                        ({2'b0, px_reg} > DOT)
                        && (({2'b0, px_reg} + DOT) < {2'b0, cfg.width})
                        && ({2'b0, num_reg[11:0]} > DOT)
                        && (({2'b0, num_reg[11:0]} + DOT) < {2'b0, cfg.height});
                    res_next.rescale      = job_reg.rescale;
                    res_next.sample_index = job_reg.idx[23:0];
                    prev_x_next = px_reg;
                    prev_y_next = num_reg[11:0];
                    valid_next  = 1'b1;
                    state_next  = pspm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = pspm_pkg::B_IDLE;
            end
        endcase
        if (dot && state_reg == pspm_pkg::B_IDLE)
        begin
            px_next = px_reg;
        end
    end

endmodule

// File: hdl/plot_sample_to_pixel_mapper_unit.sv
// top level of the plot sample to pixel mapper
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser opcode, tdata x_value, y_value
//  m_*       out        m_tvalid/m_tready  tdata pixel and flag fields
//  cfg_*     in         cfg_write          cfg_index, cfg_data
//
// on the fixed grid the front end works out the slot count by a serial division.
// the back end runs up to two serial 45-step divisions through one shared divider;
// an empty window or a value below it skips one. the two-entry queue lets the
// front end take new samples while the back end divides; the output register
// holds a result until it is taken. a clear resets the sample count and gives no
// result. reset clears the count, slot count, previous pixel and all valid flags.
module plot_sample_to_pixel_mapper_unit #(
    parameter int DOT_RADIUS = 2,
    parameter int COUNT_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_value, y_value
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pixel_x, pixel_y, line_valid, line_from_x,
                                   // line_from_y, dot_visible, rescale, sample_index
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pspm_pkg::cfg_t    cfg_reg, cfg_next;
    pspm_pkg::job_t    push_data, pop_data;
    pspm_pkg::result_t res;
    logic              q_push, q_pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= pspm_pkg::MODE_FIXED;
            cfg_reg.x_min     <= 32'sd0;
            cfg_reg.x_max     <= 32'sd65536;
            cfg_reg.y_min     <= 32'sd0;
            cfg_reg.y_max     <= 32'sd65536;
            cfg_reg.width     <= 12'd720;
            cfg_reg.height    <= 12'd240;
            cfg_reg.min_slots <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pspm_pkg::REG_MODE:      cfg_next.mode      = cfg_data[1:0];
                pspm_pkg::REG_X_MIN:     cfg_next.x_min     = cfg_data;
                pspm_pkg::REG_X_MAX:     cfg_next.x_max     = cfg_data;
                pspm_pkg::REG_Y_MIN:     cfg_next.y_min     = cfg_data;
                pspm_pkg::REG_Y_MAX:     cfg_next.y_max     = cfg_data;
                pspm_pkg::REG_WIDTH:     cfg_next.width     = cfg_data[11:0];
                pspm_pkg::REG_HEIGHT:    cfg_next.height    = cfg_data[11:0];
                pspm_pkg::REG_MIN_SLOTS: cfg_next.min_slots = cfg_data[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    pspm_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_opcode(s_tuser),
        .in_x     (s_tdata[31:0]),
        .in_y     (s_tdata[63:32]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    pspm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(push_data),
        .pop      (q_pop),
        .pop_data (pop_data),
        .full     (q_full),
        .empty    (q_empty)
    );

    pspm_back #(
        .DOT_RADIUS(DOT_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res)
    );

    assign m_tdata = {5'b0, res};

endmodule

// File: test/tb.sv
// self-checking testbench of the plot sample to pixel mapper
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // x_value, y_value
    logic        s_tuser = 1'b0; // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // pixel_x, pixel_y, line_valid, line_from_x,
                                 // line_from_y, dot_visible, rescale, sample_index
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    plot_sample_to_pixel_mapper_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #6000000;
        $display("tb: FAIL");
        $finish;
    end

    // mirror of the block state and registers
    pspm_pkg::cfg_t mcfg;
    logic [23:0] cnt;
    longint      last_slots;
    logic [11:0] prev_x, prev_y;

    pspm_pkg::result_t pixel_queue[$];
    int          errors = 0;
    int          checked = 0;
    int          cfg_writes = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    typedef struct {
        bit                is_cfg;
        logic [2:0]        idx;
        logic [31:0]       xv;
        logic [31:0]       yv;
        bit                op;
        bit                has_exp;
        pspm_pkg::result_t exp;
    } row_t;
    row_t rows[$];

    function automatic logic [11:0] scale_axis(longint v, longint lo, longint hi, longint m);
        longint range, q;
        range = hi - lo;
        if (range != 0)
            q = ((v - lo) * m) / range;
        else
            q = (v >= 0) ? v / 65536 : -1;
        if (q < 0)
            q = 0;
        if (q > m)
            q = m;
        return q[11:0];
    endfunction

    function automatic bit map_sample(bit op, logic [31:0] xv, logic [31:0] yv,
                                      output pspm_pkg::result_t r);
        longint idx, n, pm, slots, px, py, w, h;
        logic [11:0] sy;
        bit resc;
        resc = 1'b0;
        r = '0;
        if (op == pspm_pkg::OP_CLEAR)
        begin
            cnt = '0;
            return 1'b0;
        end
        idx = cnt;
        n = idx + 1;
        pm = (mcfg.min_slots == 0) ? 1 : mcfg.min_slots;
        w = mcfg.width;
        h = mcfg.height;
        if (mcfg.mode == pspm_pkg::MODE_FIXED || mcfg.mode == pspm_pkg::MODE_DYNAMIC)
        begin
            if (mcfg.mode == pspm_pkg::MODE_FIXED)
                slots = pm * (n / pm + 1);
            else
                slots = (n > pm) ? n : pm;
            if (slots != last_slots)
            begin
                resc = 1'b1;
                last_slots = slots;
            end
            px = (idx * w) / slots;
        end
        else
            px = scale_axis(longint'($signed(xv)), longint'(mcfg.x_min),
                            longint'(mcfg.x_max), w);
        sy = scale_axis(longint'($signed(yv)), longint'(mcfg.y_min),
                        longint'(mcfg.y_max), h);
        py = h - sy;
        r.pixel_x = px[11:0];
        r.pixel_y = py[11:0];
        r.line_valid = (idx != 0);
        r.line_from_x = prev_x;
        r.line_from_y = prev_y;
        r.dot_visible = (px > 2) && (px + 2 < w) && (py > 2) && (py + 2 < h);
        r.rescale = resc;
        r.sample_index = idx[23:0];
        prev_x = px[11:0];
        prev_y = py[11:0];
        if (cnt != 24'hFFFFFF)
            cnt = cnt + 1'b1;
        return 1'b1;
    endfunction

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            pspm_pkg::REG_MODE:   mcfg.mode = data[1:0];
            pspm_pkg::REG_X_MIN:  mcfg.x_min = data;
            pspm_pkg::REG_X_MAX:  mcfg.x_max = data;
            pspm_pkg::REG_Y_MIN:  mcfg.y_min = data;
            pspm_pkg::REG_Y_MAX:  mcfg.y_max = data;
            pspm_pkg::REG_WIDTH:  mcfg.width = data[11:0];
            pspm_pkg::REG_HEIGHT: mcfg.height = data[11:0];
            default:              mcfg.min_slots = data[15:0];
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // wait for every result, then let the clock run on with no input
    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send(bit op, logic [31:0] xv, logic [31:0] yv, bit has_exp,
                        pspm_pkg::result_t want);
        pspm_pkg::result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {yv, xv};
        do
            @(posedge clk);
        while (!s_tready);
        if (map_sample(op, xv, yv, r))
            pixel_queue.push_back(has_exp ? want : r);
    endtask

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= rcv_idle);

    always @(posedge clk)
    begin
        pspm_pkg::result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[74:0];
            if (pixel_queue.size() == 0)
                report("unexpected result", got.sample_index, 24'd0);
            else
            begin
                want = pixel_queue.pop_front();
                checked++;
                if (got.pixel_x != want.pixel_x)
                    report("pixel_x", got.pixel_x, want.pixel_x);
                if (got.pixel_y != want.pixel_y)
                    report("pixel_y", got.pixel_y, want.pixel_y);
                if (got.line_valid != want.line_valid)
                    report("line_valid", got.line_valid, want.line_valid);
                if (got.line_from_x != want.line_from_x)
                    report("line_from_x", got.line_from_x, want.line_from_x);
                if (got.line_from_y != want.line_from_y)
                    report("line_from_y", got.line_from_y, want.line_from_y);
                if (got.dot_visible != want.dot_visible)
                    report("dot_visible", got.dot_visible, want.dot_visible);
                if (got.rescale != want.rescale)
                    report("rescale", got.rescale, want.rescale);
                if (got.sample_index != want.sample_index)
                    report("sample_index", got.sample_index, want.sample_index);
            end
        end
    end

    function automatic void row_item(bit op, logic [31:0] xv, logic [31:0] yv);
        row_t t;
        t = '{default: '0};
        t.op = op;
        t.xv = xv;
        t.yv = yv;
        rows.push_back(t);
    endfunction

    function automatic void row_exp(logic [31:0] yv, pspm_pkg::result_t want);
        row_t t;
        t = '{default: '0};
        t.op = pspm_pkg::OP_PLOT;
        t.yv = yv;
        t.has_exp = 1'b1;
        t.exp = want;
        rows.push_back(t);
    endfunction

    function automatic void row_cfg(logic [2:0] idx, logic [31:0] data);
        row_t t;
        t = '{default: '0};
        t.is_cfg = 1'b1;
        t.idx = idx;
        t.xv = data;
        rows.push_back(t);
    endfunction

    function automatic logic [31:0] pick_value(logic signed [31:0] lo, logic signed [31:0] hi);
        longint a, b, span;
        a = lo;
        b = hi;
        if (a > b)
        begin
            span = a;
            a = b;
            b = span;
        end
        span = b - a;
        if ($urandom_range(0, 9) < 2 || span > 64'h7FFF_FFFF)
            return $urandom;
        // a little outside the window now and then, to hit the clamps
        span = span + span / 4 + 1;
        a = a - span / 10 + longint'($urandom_range(0, span));
        if (a > 64'sh7FFF_FFFF)
            a = 64'sh7FFF_FFFF;
        if (a < -64'sh8000_0000)
            a = -64'sh8000_0000;
        return a[31:0];
    endfunction

    task automatic random_window(logic [2:0] reg_lo, logic [2:0] reg_hi);
        logic signed [31:0] lo, hi;
        int kind;
        kind = $urandom_range(0, 9);
        lo = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        hi = lo + $signed($urandom_range(1, 32'h0080_0000));
        if (kind == 0)
            hi = lo;
        else if (kind == 1)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (kind == 2)
        begin
            lo = hi;
            hi = lo - 32'sd65536;
        end
        write_reg(reg_lo, lo);
        write_reg(reg_hi, hi);
    endtask

    initial
    begin
        pspm_pkg::result_t none;
        int sent;
        int sel;
        none = '0;
        mcfg = '{mode: pspm_pkg::MODE_FIXED, x_min: 0, x_max: 65536, y_min: 0,
                 y_max: 65536, width: 720, height: 240, min_slots: 100};
        cnt = '0;
        last_slots = 0;
        prev_x = '0;
        prev_y = '0;

        // defaults after reset
        row_exp(32'h0000_0000, '{24'd0, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0, 12'd240, 12'd0});
        row_exp(32'h0000_8000, '{24'd1, 1'b0, 1'b1, 12'd240, 12'd0, 1'b1, 12'd120, 12'd7});
        row_item(pspm_pkg::OP_PLOT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        row_item(pspm_pkg::OP_PLOT, 32'h0000_0000, 32'h8000_0000);
        row_item(pspm_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row_item(pspm_pkg::OP_PLOT, 32'h1234_5678, 32'h0001_0000);
        // dynamic slots with a zero minimum
        row_cfg(pspm_pkg::REG_MODE, pspm_pkg::MODE_DYNAMIC);
        row_cfg(pspm_pkg::REG_MIN_SLOTS, 32'd0);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0000_4000);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0000_c000);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0000_2000);
        // xy over the full signed x window
        row_cfg(pspm_pkg::REG_MODE, pspm_pkg::MODE_XY);
        row_cfg(pspm_pkg::REG_X_MIN, 32'h8000_0000);
        row_cfg(pspm_pkg::REG_X_MAX, 32'h7FFF_FFFF);
        row_item(pspm_pkg::OP_PLOT, 32'h8000_0000, 32'h0000_8000);
        row_item(pspm_pkg::OP_PLOT, 32'h7FFF_FFFF, 32'h0000_8000);
        row_item(pspm_pkg::OP_PLOT, 32'h0000_0000, 32'h0000_8000);
        // zero range windows take the integer part of the value
        row_cfg(pspm_pkg::REG_X_MIN, 32'h0);
        row_cfg(pspm_pkg::REG_X_MAX, 32'h0);
        row_cfg(pspm_pkg::REG_Y_MIN, 32'h0);
        row_cfg(pspm_pkg::REG_Y_MAX, 32'h0);
        row_item(pspm_pkg::OP_PLOT, 32'h0005_0000, 32'h0050_8000);
        row_item(pspm_pkg::OP_PLOT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        // zero size graph
        row_cfg(pspm_pkg::REG_WIDTH, 32'd0);
        row_cfg(pspm_pkg::REG_HEIGHT, 32'd0);
        row_item(pspm_pkg::OP_PLOT, 32'h0005_0000, 32'h0003_0000);
        // unused mode three behaves as xy
        row_cfg(pspm_pkg::REG_MODE, 32'd3);
        row_cfg(pspm_pkg::REG_WIDTH, 32'd4095);
        row_cfg(pspm_pkg::REG_HEIGHT, 32'd4095);
        row_item(pspm_pkg::OP_PLOT, 32'h0100_0000, 32'h0020_0000);
        // largest sizes on the fixed grid
        row_cfg(pspm_pkg::REG_MODE, pspm_pkg::MODE_FIXED);
        row_cfg(pspm_pkg::REG_MIN_SLOTS, 32'd65535);
        row_cfg(pspm_pkg::REG_Y_MAX, 32'h0400_0000);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0200_0000);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'hFFFF_0000);
        row_cfg(pspm_pkg::REG_MIN_SLOTS, 32'd1);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0100_0000);
        row_item(pspm_pkg::OP_PLOT, 32'h0, 32'h0300_0000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle = 6;
        rcv_idle = 77;
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                if (i == 0 || !rows[i-1].is_cfg)
                    drain();
                write_reg(rows[i].idx, rows[i].xv);
            end
            else
                send(rows[i].op, rows[i].xv, rows[i].yv, rows[i].has_exp,
                     rows[i].has_exp ? rows[i].exp : none);
        end

        sent = 0;
        while (sent < 1300)
        begin
            if (sent == 433)
            begin
                snd_idle = 77;
                rcv_idle = 6;
            end
            else if (sent == 866)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if (sent % 100 == 0)
            begin
                drain();
                write_reg(pspm_pkg::REG_MODE, $urandom_range(0, 3));
                random_window(pspm_pkg::REG_X_MIN, pspm_pkg::REG_X_MAX);
                random_window(pspm_pkg::REG_Y_MIN, pspm_pkg::REG_Y_MAX);
                sel = $urandom_range(0, 9);
                write_reg(pspm_pkg::REG_WIDTH,
                          sel == 0 ? 4095 : (sel == 1 ? 1 : $urandom_range(1, 4095)));
                sel = $urandom_range(0, 9);
                write_reg(pspm_pkg::REG_HEIGHT,
                          sel == 0 ? 4095 : (sel == 1 ? 0 : $urandom_range(1, 4095)));
                sel = $urandom_range(0, 9);
                write_reg(pspm_pkg::REG_MIN_SLOTS,
                          sel == 0 ? 65535 : (sel == 1 ? 0 : $urandom_range(1, 150)));
            end
            // sender holds off until the block has emptied
            if (sent == 650)
                drain();
            send(($urandom_range(0, 99) < 3) ? pspm_pkg::OP_CLEAR : pspm_pkg::OP_PLOT,
                 pick_value(mcfg.x_min, mcfg.x_max),
                 pick_value(mcfg.y_min, mcfg.y_max), 1'b0, none);
            sent++;
        end

        drain();
        $display("tb: %0d results checked over %0d register writes", checked, cfg_writes);
        $display("tb: fixed, dynamic and xy modes, clears, zero ranges and size extremes");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// File: files.f
hdl/pspm_pkg.sv
hdl/pspm_front.sv
hdl/pspm_queue.sv
hdl/pspm_back.sv
hdl/plot_sample_to_pixel_mapper_unit.sv
test/tb.sv
